// ===== sv/esc_pkg.sv =====
// Constants and lookup functions shared by the epoch seconds to calendar converter.
package esc_pkg;

  // Pipeline depth, from the input register stage to the output register.
  localparam int STAGES = 7;

  // Calendar constants.
  localparam logic [9:0]  DAY_SECS_DIV128 = 10'd675;      // 86400 / 128
  localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
  localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;
  localparam logic [2:0]  EPOCH_WEEKDAY   = 3'd4;         // 1970-01-01 was a Thursday
  localparam logic [19:0] DAYS_TO_MARCH   = 20'd719468;   // 719527 - 59
  localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
  localparam logic [6:0]  YEARS_CENTURY   = 7'd100;
  localparam logic [8:0]  YEARS_CYCLE     = 9'd400;
  localparam logic [8:0]  YDAY_JANUARY    = 9'd306;       // March-based day of 1 January
  localparam logic [4:0]  YDAY_MON_BIAS   = 5'd31;
  localparam logic [3:0]  MONTH_WRAP      = 4'd10;
  localparam logic [3:0]  MONTH_SHIFT     = 4'd2;

  // Reciprocals for exact division by constants: q = (x * RCP) >> SHIFT.
  localparam logic [25:0] RCP_675   = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
  localparam logic [29:0] RCP_YEAR  =
    30'(((64'd1 << 38) * 64'd400 + 64'd146096) / 64'd146097);
  localparam logic [16:0] RCP_7     = 17'(((64'd1 << 19) + 64'd6) / 64'd7);
  localparam logic [16:0] RCP_15_20 = 17'(((64'd1 << 20) + 64'd14) / 64'd15);
  localparam logic [12:0] RCP_15_16 = 13'(((64'd1 << 16) + 64'd14) / 64'd15);
  localparam logic [10:0] RCP_25    = 11'(((64'd1 << 15) + 64'd24) / 64'd25);
  localparam logic [12:0] RCP_MON   = 13'(((64'd1 << 17) * 64'd5 + 64'd152) / 64'd153);

  // First March-based day of year of month index m, i.e. 367 * m / 12 - 30.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd61;
      4'd4:    v = 9'd92;
      4'd5:    v = 9'd122;
      4'd6:    v = 9'd153;
      4'd7:    v = 9'd184;
      4'd8:    v = 9'd214;
      4'd9:    v = 9'd245;
      4'd10:   v = 9'd275;
      4'd11:   v = 9'd306;
      4'd12:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/epoch_seconds_to_calendar.sv =====
// Epoch seconds to UTC calendar converter, a seven-stage pipeline.
//
// This block turns an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// the UTC second, minute, hour, day of month, month (1 is January), full year and weekday
// (0 is Sunday), covering every input up to 2106-02-07. It accepts one transfer in every
// clock cycle while the output side is ready or a stage is empty, and each result passes
// through the seven register stages, which hold the constant-reciprocal multiplications
// and the adds around them. Every stage carries its own valid bit and only stalls while
// its successor is full, so idle slots close up under back-pressure and nothing is lost
// or repeated. The block holds no state besides the pipeline, and the date follows the
// March-based year method: count days from 1 March of 1 BC, estimate the year, step back
// once when the day of year comes out negative, map day of year to month and finally
// move the year start to January.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
  // [25:22] month, [37:26] year, [40:38] weekday, [47:41] zero
  output logic [47:0] out_tdata
);

  localparam int NS = esc_pkg::STAGES;

  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;

  // A stage may load when it is empty or when its content moves on in the same cycle.
  always_comb begin
    adv[NS] = out_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Stage 0: whole days. The low seven bits are split off so the divisor becomes 675.
  logic [24:0] s0_x;
  logic [50:0] s0_prod;
  logic [15:0] s0_days_nxt;
  logic [15:0] s0_days_r;
  logic [24:0] s0_x_r;
  logic [6:0]  s0_lo_r;

  assign s0_x        = in_tdata[31:7];
  assign s0_prod     = 51'(s0_x) * 51'(esc_pkg::RCP_675);
  assign s0_days_nxt = s0_prod[50:35];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_days_r <= s0_days_nxt;
      s0_x_r    <= s0_x;
      s0_lo_r   <= in_tdata[6:0];
    end
  end

  // Stage 1: seconds of the day, day count from 1 March of 1 BC, year estimate and
  // the quotient for the weekday.
  logic [24:0] s1_dmul;
  logic [24:0] s1_rdiff;
  logic [16:0] s1_rem_nxt;
  logic [19:0] s1_mdays_nxt;
  logic [19:0] s1_w;
  logic [49:0] s1_yprod;
  logic [15:0] s1_d4_nxt;
  logic [32:0] s1_wprod;
  logic [16:0] s1_rem_r;
  logic [19:0] s1_mdays_r;
  logic [11:0] s1_yr_r;
  logic [15:0] s1_d4_r;
  logic [13:0] s1_q7_r;

  assign s1_dmul      = 25'(s0_days_r) * 25'(esc_pkg::DAY_SECS_DIV128);
  assign s1_rdiff     = s0_x_r - s1_dmul;
  assign s1_rem_nxt   = {s1_rdiff[9:0], s0_lo_r};
  assign s1_mdays_nxt = 20'(s0_days_r) + esc_pkg::DAYS_TO_MARCH;
  assign s1_w         = 20'(s0_days_r) + esc_pkg::DAYS_TO_MARCH + 20'd2;
  assign s1_yprod     = 50'(s1_w) * 50'(esc_pkg::RCP_YEAR);
  assign s1_d4_nxt    = s0_days_r + 16'(esc_pkg::EPOCH_WEEKDAY);
  assign s1_wprod     = 33'(s1_d4_nxt) * 33'(esc_pkg::RCP_7);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_rem_r   <= s1_rem_nxt;
      s1_mdays_r <= s1_mdays_nxt;
      s1_yr_r    <= s1_yprod[49:38];
      s1_d4_r    <= s1_d4_nxt;
      s1_q7_r    <= s1_wprod[32:19];
    end
  end

  // Stage 2: minutes of the day, weekday, century counts and 365 times the year.
  logic [31:0] s2_tprod;
  logic [15:0] s2_wdiff;
  logic [20:0] s2_p100;
  logic [18:0] s2_p400;
  logic [19:0] s2_y365_nxt;
  logic [16:0] s2_rem_r;
  logic [10:0] s2_tm_r;
  logic [2:0]  s2_wday_r;
  logic [11:0] s2_yr_r;
  logic [19:0] s2_mdays_r;
  logic [4:0]  s2_c100_r;
  logic [2:0]  s2_c400_r;
  logic [19:0] s2_y365_r;

  assign s2_tprod    = 32'(s1_rem_r[16:2]) * 32'(esc_pkg::RCP_15_20);
  assign s2_wdiff    = s1_d4_r - 16'(s1_q7_r) * 16'(esc_pkg::DAYS_PER_WEEK);
  assign s2_p100     = 21'(s1_yr_r[11:2]) * 21'(esc_pkg::RCP_25);
  assign s2_p400     = 19'(s1_yr_r[11:4]) * 19'(esc_pkg::RCP_25);
  assign s2_y365_nxt = 20'(s1_yr_r) * 20'(esc_pkg::DAYS_PER_YEAR);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_rem_r   <= s1_rem_r;
      s2_tm_r    <= s2_tprod[30:20];
      s2_wday_r  <= s2_wdiff[2:0];
      s2_yr_r    <= s1_yr_r;
      s2_mdays_r <= s1_mdays_r;
      s2_c100_r  <= s2_p100[19:15];
      s2_c400_r  <= s2_p400[17:15];
      s2_y365_r  <= s2_y365_nxt;
    end
  end

  // Stage 3: day of year against the estimated year start, leap flag, second and hour.
  logic [19:0] s3_base;
  logic [19:0] s3_ydiff;
  logic        s3_leap_nxt;
  logic [16:0] s3_sdiff;
  logic [21:0] s3_hprod;
  logic [10:0] s3_yday_r;
  logic        s3_leap_r;
  logic [11:0] s3_yr_r;
  logic [5:0]  s3_sec_r;
  logic [4:0]  s3_hr_r;
  logic [10:0] s3_tm_r;
  logic [2:0]  s3_wday_r;

  assign s3_base  = s2_y365_r + 20'(s2_yr_r[11:2]) - 20'(s2_c100_r) + 20'(s2_c400_r);
  assign s3_ydiff = s2_mdays_r - s3_base;
  assign s3_leap_nxt = (s2_yr_r[1:0] == 2'd0) &&
                       ((12'(s2_c100_r) * 12'(esc_pkg::YEARS_CENTURY) != s2_yr_r) ||
                        (12'(s2_c400_r) * 12'(esc_pkg::YEARS_CYCLE) == s2_yr_r));
  assign s3_sdiff = s2_rem_r - 17'(s2_tm_r) * 17'(esc_pkg::SECS_PER_MIN);
  assign s3_hprod = 22'(s2_tm_r[10:2]) * 22'(esc_pkg::RCP_15_16);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_yday_r <= s3_ydiff[10:0];
      s3_leap_r <= s3_leap_nxt;
      s3_yr_r   <= s2_yr_r;
      s3_sec_r  <= s3_sdiff[5:0];
      s3_hr_r   <= s3_hprod[20:16];
      s3_tm_r   <= s2_tm_r;
      s3_wday_r <= s2_wday_r;
    end
  end

  // Stage 4: minute of the hour, and a negative day of year steps back into the previous March-based year.
  logic [10:0] s4_yfix;
  logic [8:0]  s4_yday_nxt;
  logic [11:0] s4_yr_nxt;
  logic [10:0] s4_mdiff;
  logic [8:0]  s4_yday_r;
  logic [11:0] s4_yr_r;
  logic [5:0]  s4_sec_r;
  logic [5:0]  s4_min_r;
  logic [4:0]  s4_hr_r;
  logic [2:0]  s4_wday_r;

  assign s4_yfix  = s3_yday_r + 11'(esc_pkg::DAYS_PER_YEAR) + 11'(s3_leap_r);
  assign s4_mdiff = s3_tm_r - 11'(s3_hr_r) * 11'(esc_pkg::SECS_PER_MIN);

  always_comb begin
    if (s3_yday_r[10]) begin
      s4_yday_nxt = s4_yfix[8:0];
      s4_yr_nxt   = s3_yr_r - 12'd1;
    end else begin
      s4_yday_nxt = s3_yday_r[8:0];
      s4_yr_nxt   = s3_yr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_yday_r <= s4_yday_nxt;
      s4_yr_r   <= s4_yr_nxt;
      s4_sec_r  <= s3_sec_r;
      s4_min_r  <= s4_mdiff[5:0];
      s4_hr_r   <= s3_hr_r;
      s4_wday_r <= s3_wday_r;
    end
  end

  // Stage 5: month index of the March-based year, (yday + 31) * 5 / 153.
  logic [8:0]  s5_a;
  logic [21:0] s5_mprod;
  logic [3:0]  s5_mon_r;
  logic [8:0]  s5_yday_r;
  logic [11:0] s5_yr_r;
  logic [5:0]  s5_sec_r;
  logic [5:0]  s5_min_r;
  logic [4:0]  s5_hr_r;
  logic [2:0]  s5_wday_r;

  assign s5_a     = s4_yday_r + 9'(esc_pkg::YDAY_MON_BIAS);
  assign s5_mprod = 22'(s5_a) * 22'(esc_pkg::RCP_MON);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_mon_r  <= s5_mprod[20:17];
      s5_yday_r <= s4_yday_r;
      s5_yr_r   <= s4_yr_r;
      s5_sec_r  <= s4_sec_r;
      s5_min_r  <= s4_min_r;
      s5_hr_r   <= s4_hr_r;
      s5_wday_r <= s4_wday_r;
    end
  end

  // Stage 6 (output register): day of month and the move of the year start to January.
  logic [8:0]  s6_mday;
  logic [3:0]  s6_mon_nxt;
  logic [11:0] s6_yr_nxt;
  logic [4:0]  out_mday_r;
  logic [3:0]  out_mon_r;
  logic [11:0] out_yr_r;
  logic [5:0]  out_sec_r;
  logic [5:0]  out_min_r;
  logic [4:0]  out_hr_r;
  logic [2:0]  out_wday_r;

  assign s6_mday = s5_yday_r - esc_pkg::month_start(s5_mon_r) + 9'd1;

  always_comb begin
    if (s5_yday_r >= esc_pkg::YDAY_JANUARY) begin
      s6_yr_nxt  = s5_yr_r + 12'd1;
      s6_mon_nxt = s5_mon_r - esc_pkg::MONTH_WRAP;
    end else begin
      s6_yr_nxt  = s5_yr_r;
      s6_mon_nxt = s5_mon_r + esc_pkg::MONTH_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      out_mday_r <= s6_mday[4:0];
      out_mon_r  <= s6_mon_nxt;
      out_yr_r   <= s6_yr_nxt;
      out_sec_r  <= s5_sec_r;
      out_min_r  <= s5_min_r;
      out_hr_r   <= s5_hr_r;
      out_wday_r <= s5_wday_r;
    end
  end

  assign out_tdata = {7'd0, out_wday_r, out_yr_r, out_mon_r, out_mday_r,
                      out_hr_r, out_min_r, out_sec_r};

  // A delivered date always names a real month and day.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_mon_r >= 4'd1) && (out_mon_r <= 4'd12) && (out_mday_r != 5'd0))
    else $error("calendar date out of range");

  // The time of day and weekday fields stay within their ranges together.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_hr_r <= 5'd23) && (out_min_r <= 6'd59) && (out_sec_r <= 6'd59) &&
                   (out_wday_r <= 3'd6))
    else $error("time of day out of range");

  // A full pipeline behind a stalled output must not take a new transfer.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && !out_tready) |-> !in_tready)
    else $error("transfer accepted into a full stalled pipeline");

  // The first stage keeps its valid item while its successor stalls.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !adv[1]) |=> vld_r[0])
    else $error("stalled stage dropped its item");

endmodule

// ===== tb/calendar_checker.sv =====
// Checker that predicts the calendar fields of every accepted epoch time and compares results.
`timescale 1ns / 100ps

module calendar_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          mismatches,
  output int          dates_pending
);

  typedef struct packed {
    logic [31:0] seconds;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
  } utc_date_t;

  utc_date_t expected_dates[$];
  utc_date_t want;

  initial mismatches = 0;
  initial dates_pending = 0;

  function automatic bit is_leap_year(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Calendar fields of an epoch time, worked out with years that begin on 1 March.
  function automatic utc_date_t seconds_to_calendar(input logic [31:0] secs);
    longint total, day_count, day_secs, march_days, yr, yd, mo, md;
    utc_date_t d;
    total      = secs;
    day_count  = total / 86400;
    day_secs   = total % 86400;
    d.seconds  = secs;
    d.weekday  = 3'((4 + day_count) % 7);
    d.hour     = 5'(day_secs / 3600);
    d.minute   = 6'((day_secs % 3600) / 60);
    d.second   = 6'(day_secs % 60);
    march_days = day_count + 719468;
    yr = (march_days + 2) * 400 / 146097;
    yd = march_days - (365 * yr + yr / 4 - yr / 100 + yr / 400);
    // The year estimate can overshoot by one just before 1 March.
    if (yd < 0) begin
      yd = 365 + (is_leap_year(yr) ? 1 : 0) + yd;
      yr = yr - 1;
    end
    mo = (yd + 31) * 10 / 306;
    md = yd - (367 * mo / 12 - 30) + 1;
    // January and February belong to the next calendar year.
    if (yd >= 306) begin
      yr = yr + 1;
      mo = mo - 10;
    end else begin
      mo = mo + 2;
    end
    d.mday  = 5'(md);
    d.month = 4'(mo);
    d.year  = 12'(yr);
    return d;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint wanted,
                                 input logic [31:0] secs);
    if (mismatches < 100)
      $display("%0t: %s for seconds %0d: got %0d, expected %0d", $realtime, what, secs, got,
               wanted);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_tdata, 0, 32'd0);
        end else begin
          want = expected_dates.pop_front();
          if (out_tdata[5:0] != want.second)
            report_mismatch("second", out_tdata[5:0], want.second, want.seconds);
          if (out_tdata[11:6] != want.minute)
            report_mismatch("minute", out_tdata[11:6], want.minute, want.seconds);
          if (out_tdata[16:12] != want.hour)
            report_mismatch("hour", out_tdata[16:12], want.hour, want.seconds);
          if (out_tdata[21:17] != want.mday)
            report_mismatch("day_of_month", out_tdata[21:17], want.mday, want.seconds);
          if (out_tdata[25:22] != want.month)
            report_mismatch("month", out_tdata[25:22], want.month, want.seconds);
          if (out_tdata[37:26] != want.year)
            report_mismatch("year", out_tdata[37:26], want.year, want.seconds);
          if (out_tdata[40:38] != want.weekday)
            report_mismatch("weekday", out_tdata[40:38], want.weekday, want.seconds);
        end
      end
      if (in_tvalid && in_tready)
        expected_dates.push_back(seconds_to_calendar(in_tdata));
    end
    dates_pending <= expected_dates.size();
  end

endmodule

// ===== tb/epoch_seconds_to_calendar_tb.sv =====
// Testbench top for the epoch seconds to calendar converter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;

  // The receiver's long hold-off, long enough to fill all seven stages and stall the input.
  localparam int LONG_HOLD    = 300;
  // Cycles without any transfer before the run is declared hung.
  localparam int IDLE_LIMIT   = 4000;
  // Cycles waited after the last result, more than a result needs to pass the seven stages.
  localparam int DRAIN_CYCLES = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = 32'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  int mismatches;
  int dates_pending;
  int idle_cycles = 0;

  // Set by the stimulus to make the receiver hold off once; cleared by the receiver.
  bit hold_output = 1'b0;
  // High while the receiver is inside its long hold-off.
  bit holding = 1'b0;
  // While set, neither side idles, so transfers go back to back.
  bit steady = 1'b0;

  // Corner times: the ends of the range, the signed 32-bit rollover, day and hour
  // boundaries, the leap day of 1972 and 2000, the turn of 1999 to 2000, and the end of
  // February 2100, a century year that is not a leap year.
  logic [31:0] corner_seconds [24] = '{
    32'd0,          32'd1,          32'd59,         32'd60,
    32'd3599,       32'd3600,       32'd86399,      32'd86400,
    32'd68169600,   32'd68255999,   32'd68256000,   32'd946684799,
    32'd946684800,  32'd951782400,  32'd951868800,  32'd4107455999,
    32'd4107542399, 32'd4107542400, 32'd2147483647, 32'd2147483648,
    32'd4294967295, 32'd4294967294, 32'hAAAAAAAA,   32'h55555555
  };

  always #2 clk = ~clk;

  epoch_seconds_to_calendar dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  calendar_checker date_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .dates_pending (dates_pending)
  );

  // Random epoch time. Plain uniform values make every input bit toggle; the rest lands
  // near 1 March and 1 January of random years, where the year estimate needs its
  // correction and the year start moves, near day boundaries, and near both range ends.
  function automatic logic [31:0] pick_seconds();
    longint yr, march_first, base_day, s;
    int     r, day_shift;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      s = $urandom();
    end else if (r < 75) begin
      yr          = $urandom_range(1969, 2105);
      // Days from the epoch to 1 March of the March-based year yr.
      march_first = 365 * yr + yr / 4 - yr / 100 + yr / 400 - 719468;
      base_day    = $urandom_range(0, 1) ? march_first : march_first + 306;
      day_shift   = int'($urandom_range(0, 4)) - 2;
      s = (base_day + day_shift) * 86400 + longint'($urandom_range(0, 86399));
    end else if (r < 90) begin
      s = longint'($urandom_range(0, 49710)) * 86400;
      case ($urandom_range(0, 2))
        0:       s = s + 86399;
        1:       s = s + longint'($urandom_range(0, 86399));
        default: s = s;
      endcase
    end else begin
      s = $urandom_range(0, 1) ? longint'($urandom_range(0, 200000))
                               : 64'hFFFFFFFF - longint'($urandom_range(0, 200000));
    end
    // Anything pushed outside the 32-bit range falls back to a uniform value.
    if (s < 0 || s > 64'hFFFFFFFF)
      s = $urandom();
    return 32'(s);
  endfunction

  // Offers one time and returns at the falling edge after its transfer.
  task automatic send_seconds(input logic [31:0] secs);
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random gap between input transfers: mostly none or short, now and then long.
  task automatic sender_gap();
    int r, gap;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 55)      gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else             gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      send_seconds(pick_seconds());
      sender_gap();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_seconds[i]) begin
      send_seconds(corner_seconds[i]);
      sender_gap();
    end

    send_random(500);

    // The receiver holds off while the sender keeps offering back to back, so the
    // pipeline fills and in_tready drops. The sender starts only once the hold-off has
    // begun. Afterwards the sender pauses until every outstanding result has come out.
    hold_output = 1'b1;
    steady      = 1'b1;
    in_tvalid  <= 1'b0;
    wait (holding);
    send_random(40);
    steady      = 1'b0;
    in_tvalid  <= 1'b0;
    wait (dates_pending == 0);
    @(negedge clk);

    // A stretch with no idling on either side, then random flow control again.
    steady = 1'b1;
    send_random(200);
    steady = 1'b0;
    send_random(360);

    in_tvalid <= 1'b0;
    wait (dates_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && dates_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver flow control. Each pass holds out_tready for a stretch of cycles; the one
  // long hold-off is counted here so that the sender carries on independently.
  initial begin
    int r, stretch;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_tready <= 1'b0;
        holding = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_output = 1'b0;
        holding = 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_tready <= 1'b1;
          stretch = $urandom_range(1, 8);
        end else if (r < 80) begin
          out_tready <= 1'b0;
          stretch = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_tready <= 1'b1;
          stretch = $urandom_range(10, 40);
        end else begin
          out_tready <= 1'b0;
          stretch = $urandom_range(15, 60);
        end
        repeat (stretch - 1) @(negedge clk);
      end
    end
  end

  // Watchdog: a run in which no transfer happens for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
